FILE: hdl/mss_pkg.sv
// mss_pkg: codes, register defaults and payload types of the motor safety supervisor
package mss_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_COMMAND_TIMEOUT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_STALL_SETPOINT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STALL_ACTUAL    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_STALL_TIME      = 2'd3;

    localparam logic [15:0] COMMAND_TIMEOUT_RST = 16'd500;
    localparam logic [14:0] STALL_SETPOINT_RST  = 15'd205;
    localparam logic [14:0] STALL_ACTUAL_RST    = 15'd51;
    localparam logic [15:0] STALL_TIME_RST      = 16'd1000;

    localparam logic [2:0] KIND_ARM     = 3'd0;
    localparam logic [2:0] KIND_DISARM  = 3'd1;
    localparam logic [2:0] KIND_CLEAR   = 3'd2;
    localparam logic [2:0] KIND_COMMAND = 3'd3;
    localparam logic [2:0] KIND_TICK    = 3'd4;

    localparam logic [1:0] MODE_DISARMED  = 2'd0;
    localparam logic [1:0] MODE_ARMED     = 2'd1;
    localparam logic [1:0] MODE_SOFT_STOP = 2'd2;
    localparam logic [1:0] MODE_EMERGENCY = 2'd3;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_LEFT    = 2'd2;
    localparam logic [1:0] CAUSE_RIGHT   = 2'd3;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        now_ms;
        logic signed [15:0] left_measured;
        logic signed [15:0] left_setpoint;
        logic signed [15:0] right_measured;
        logic signed [15:0] right_setpoint;
    } item_t;

    typedef struct packed {
        logic [1:0] safety_mode;
        logic [1:0] cause;
        logic       refused;
        logic       stalling;
    } result_t;

    typedef struct packed {
        logic [15:0] command_timeout_ms;
        logic [14:0] stall_setpoint_min;
        logic [14:0] stall_actual_max;
        logic [15:0] stall_time_ms;
    } cfg_t;

    // 17-bit magnitude of a 16-bit two's complement value
    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic [16:0] ext;
        ext = {1'b0, v};
        return v[15] ? (17'h10000 - ext) : ext;
    endfunction

endpackage

FILE: hdl/mss_ifs.sv
// mss_ifs: channel interfaces for items, results and configuration writes
interface mss_item_if import mss_pkg::*;;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mss_result_if import mss_pkg::*;;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mss_cfg_if import mss_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

FILE: hdl/motor_safety_supervisor_unit.sv
// motor_safety_supervisor_unit: top level of the two-wheel safety supervisor
//
//  channel  dir  handshake      payload
//  item     in   valid/ready    kind, now_ms, wheel speeds (item_t)
//  result   out  valid/ready    safety_mode, cause, refused, stalling (result_t)
//  cfg      in   valid/ready    addr, wdata (always ready)
//
//  one transaction per cycle sustained while result is ready; an accepted item is registered twice
//  input register, then next-state logic, then result register
//  a stalled result holds both stages; the input register still fills while empty
//  reset clears mode, cause, command and stall state and loads register defaults
module motor_safety_supervisor_unit import mss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    mss_item_if.sink      item,
    mss_result_if.source  result,
    mss_cfg_if.sink       cfg
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_data_reg, in_data_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    logic    advance;
    logic    step;
    cfg_t    settings;
    result_t core_res;

    assign advance    = !out_valid_reg || result.ready;
    assign step       = in_valid_reg && advance;
    assign item.ready = !in_valid_reg || advance;

    mss_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    mss_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (in_data_reg),
        .settings (settings),
        .res      (core_res)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (item.ready)
        begin
            in_valid_next = item.valid;
            if (item.valid)
            begin
                in_data_next = item.data;
            end
        end
        if (advance)
        begin
            out_valid_next = in_valid_reg;
            if (step)
            begin
                out_data_next = core_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

FILE: hdl/mss_cfg_regs.sv
// mss_cfg_regs: configuration register file
module mss_cfg_regs import mss_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    mss_cfg_if.sink cfg,
    output cfg_t   settings
);

    cfg_t settings_reg;
    cfg_t settings_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        settings_next = settings_reg;
        if (cfg.valid)
        begin
            case (cfg.addr)
                REG_COMMAND_TIMEOUT: settings_next.command_timeout_ms = cfg.wdata;
                REG_STALL_SETPOINT:  settings_next.stall_setpoint_min = cfg.wdata[14:0];
                REG_STALL_ACTUAL:    settings_next.stall_actual_max   = cfg.wdata[14:0];
                REG_STALL_TIME:      settings_next.stall_time_ms      = cfg.wdata;
                default:             settings_next = settings_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.command_timeout_ms <= COMMAND_TIMEOUT_RST;
            settings_reg.stall_setpoint_min <= STALL_SETPOINT_RST;
            settings_reg.stall_actual_max   <= STALL_ACTUAL_RST;
            settings_reg.stall_time_ms      <= STALL_TIME_RST;
        end
        else
        begin
            settings_reg <= settings_next;
        end
    end

    assign settings = settings_reg;

endmodule

FILE: hdl/mss_core.sv
// mss_core: supervisor state and per-transaction next-state logic
module mss_core import mss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    settings,
    output result_t res
);

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  cause_reg, cause_next;
    logic [31:0] last_cmd_reg, last_cmd_next;
    logic        cmd_seen_reg, cmd_seen_next;
    logic        stall_run_reg, stall_run_next;
    logic [31:0] stall_begin_reg, stall_begin_next;
    logic        refused;

    logic [31:0] cmd_age;
    logic [31:0] stall_age;
    logic        cmd_late;
    logic        stall_over;
    logic        left_stall;
    logic        right_stall;

    assign cmd_age    = item.now_ms - last_cmd_reg;
    assign stall_age  = item.now_ms - stall_begin_reg;
    assign cmd_late   = cmd_age > {16'd0, settings.command_timeout_ms};
    assign stall_over = stall_age > {16'd0, settings.stall_time_ms};

    assign left_stall =
        (mag16(item.left_setpoint) > {2'b00, settings.stall_setpoint_min}) &&
        (mag16(item.left_measured) < {2'b00, settings.stall_actual_max});
    assign right_stall =
        (mag16(item.right_setpoint) > {2'b00, settings.stall_setpoint_min}) &&
        (mag16(item.right_measured) < {2'b00, settings.stall_actual_max});

    always_comb
    begin
        mode_next        = mode_reg;
        cause_next       = cause_reg;
        last_cmd_next    = last_cmd_reg;
        cmd_seen_next    = cmd_seen_reg;
        stall_run_next   = stall_run_reg;
        stall_begin_next = stall_begin_reg;
        refused          = 1'b0;
        case (item.kind)
            KIND_ARM:
            begin
                if (mode_reg == MODE_EMERGENCY)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    mode_next  = MODE_ARMED;
                    cause_next = CAUSE_NONE;
                end
            end
            KIND_DISARM:
            begin
                mode_next  = MODE_DISARMED;
                cause_next = CAUSE_NONE;
            end
            KIND_CLEAR:
            begin
                if (mode_reg == MODE_EMERGENCY)
                begin
                    mode_next      = MODE_DISARMED;
                    cause_next     = CAUSE_NONE;
                    stall_run_next = 1'b0;
                end
            end
            KIND_COMMAND:
            begin
                last_cmd_next = item.now_ms;
                cmd_seen_next = 1'b1;
            end
            KIND_TICK:
            begin
                case (mode_reg)
                    MODE_ARMED:
                    begin
                        if (cmd_seen_reg && cmd_late)
                        begin
                            mode_next  = MODE_SOFT_STOP;
                            cause_next = CAUSE_TIMEOUT;
                        end
                        else if (left_stall || right_stall)
                        begin
                            if (!stall_run_reg)
                            begin
                                stall_run_next   = 1'b1;
                                stall_begin_next = item.now_ms;
                            end
                            else if (stall_over)
                            begin
                                mode_next      = MODE_EMERGENCY;
                                cause_next     = left_stall ? CAUSE_LEFT : CAUSE_RIGHT;
                                stall_run_next = 1'b0;
                            end
                        end
                        else
                        begin
                            stall_run_next = 1'b0;
                        end
                    end
                    MODE_SOFT_STOP:
                    begin
                        if (!cmd_late)
                        begin
                            mode_next  = MODE_ARMED;
                            cause_next = CAUSE_NONE;
                        end
                    end
                    default:
                    begin
                        stall_run_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                refused = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DISARMED;
            cause_reg     <= CAUSE_NONE;
            last_cmd_reg  <= '0;
            cmd_seen_reg  <= 1'b0;
            stall_run_reg <= 1'b0;
            stall_begin_reg <= '0;
        end
        else if (step)
        begin
            mode_reg        <= mode_next;
            cause_reg       <= cause_next;
            last_cmd_reg    <= last_cmd_next;
            cmd_seen_reg    <= cmd_seen_next;
            stall_run_reg   <= stall_run_next;
            stall_begin_reg <= stall_begin_next;
        end
    end

    assign res.safety_mode = mode_next;
    assign res.cause       = cause_next;
    assign res.refused     = refused;
    assign res.stalling    = stall_run_next;

    a_disarmed_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_DISARMED |-> cause_reg == CAUSE_NONE)
        else $error("disarmed with a cause set");

    a_armed_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ARMED |-> cause_reg == CAUSE_NONE)
        else $error("armed with a cause set");

    a_soft_stop_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_SOFT_STOP |-> cause_reg == CAUSE_TIMEOUT)
        else $error("soft stop without timeout cause");

    a_emergency_stall: assert property (@(posedge clk) disable iff (!rst_n)
        step && mode_reg != MODE_EMERGENCY && mode_next == MODE_EMERGENCY
        |=> cause_reg == CAUSE_LEFT || cause_reg == CAUSE_RIGHT)
        else $error("emergency entered without stall cause");

endmodule
